>>> rtl/mrh_pkg.sv
// ----------------------------------------------------------------------------
// mrh_pkg
// Register map, access size codes and lane helpers for the register hub.
// ----------------------------------------------------------------------------
package mrh_pkg;

	// access kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// access size codes; code three is handled as a word
	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2
	} size_t;

	// word register map
	localparam logic [31:0] A_DISP_STAT = 32'h05F0_0010;
	localparam logic [31:0] A_IMS       = 32'h05FE_00A0;
	localparam logic [31:0] A_IST       = 32'h05FE_00A4;
	localparam logic [31:0] A_IST_CLR   = 32'h05FE_00A8;
	localparam logic [31:0] A_SRC_SET   = 32'h05FE_00AC;
	localparam logic [31:0] A_SRC_CLR   = 32'h05FE_00B0;
	localparam logic [31:0] A_DMA_SRC   = 32'h05FE_0020;
	localparam logic [31:0] A_DMA_LEN   = 32'h05FE_0028;
	localparam logic [31:0] A_DMA_CTL   = 32'h05FE_002C;
	localparam logic [31:0] A_CMD_STAT  = 32'h05D0_0080;
	localparam logic [31:0] A_CMD       = 32'h05D0_0084;
	localparam logic [31:0] A_CMD_RES   = 32'h05D0_0088;
	localparam logic [31:0] A_VID_MODE  = 32'h05F8_0000;
	localparam logic [31:0] A_VID_STAT  = 32'h05F8_0004;
	localparam logic [31:0] A_SND_IRQ   = 32'h05C0_0000;
	localparam logic [31:0] A_BRIDGE    = 32'h05D0_008C;
	localparam logic [31:0] A_EV_TRIG   = 32'h05D0_0090;
	localparam logic [31:0] A_EV_STAT   = 32'h05D0_0094;

	// writable masks
	localparam logic [31:0] WM_IMS      = 32'h0000_FFFF;
	localparam logic [31:0] WM_DMA_SRC  = 32'hFFFF_FFFF;
	localparam logic [31:0] WM_DMA_LEN  = 32'h000F_FFFF;
	localparam logic [31:0] WM_DMA_CTL  = 32'h0000_0017;
	localparam logic [31:0] WM_VID_MODE = 32'h0000_FFFF;
	localparam logic [31:0] WM_SND_IRQ  = 32'h0000_07FF;

	// fixed read values and tags
	localparam logic [31:0] DISP_STAT_VAL = 32'h0000_0001;
	localparam logic [31:0] CMD_STAT_VAL  = 32'h0000_0001;
	localparam logic [31:0] VID_STAT_VAL  = 32'h0000_0008;
	localparam logic [7:0]  RESULT_TAG    = 8'hA5;
	localparam int          EVENT_IRQ_BIT = 5;

	// big-endian lane shift in bits
	function automatic logic [4:0] lane_offset(input logic [1:0] addr_lo, input logic [1:0] size);
		logic [4:0] sh;
		begin
			case (size)
				SZ_BYTE: sh = {~addr_lo, 3'b000};
				SZ_HALF: sh = {~addr_lo[1], 4'b0000};
				default: sh = 5'd0;
			endcase
			return sh;
		end
	endfunction

	// size mask, right-aligned
	function automatic logic [31:0] width_mask(input logic [1:0] size);
		logic [31:0] m;
		begin
			case (size)
				SZ_BYTE: m = 32'h0000_00FF;
				SZ_HALF: m = 32'h0000_FFFF;
				default: m = 32'hFFFF_FFFF;
			endcase
			return m;
		end
	endfunction

	// merge lane-placed bits under lane and writable masks
	function automatic logic [31:0] merge(input logic [31:0] old, input logic [31:0] bits,
			input logic [31:0] lanes, input logic [31:0] writable);
		logic [31:0] m;
		begin
			m = lanes & writable;
			return (old & ~m) | (bits & m);
		end
	endfunction

endpackage

>>> rtl/mmio_register_hub_core.sv
// ----------------------------------------------------------------------------
// mmio_register_hub_core
// Big-endian byte/half/word register slave over a fixed map of word
// registers, with interrupt pending, mask and source logic, a command latch
// and an event counter.
// ----------------------------------------------------------------------------
// Read path: a read passes through the request register, then the result register,
//   from which its result is presented; writes give no result.
// Throughput: one access per cycle; the request register empties every cycle
//   unless a read result is held by a stalled response channel.
// Reset: arst_n clears both valid flags and every map register to zero.
module mmio_register_hub_core
	import mrh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        req_type,
	input  logic [31:0] address,
	input  logic [1:0]  access_size,
	input  logic [31:0] write_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [31:0] read_data
);

	// request stage
	logic        valid_s1;
	logic        type_s1;
	logic [31:0] addr_s1;
	logic [1:0]  size_s1;
	logic [31:0] wdata_s1;

	// response register
	logic        rsp_valid_q;
	logic [31:0] read_data_q;

	// register file
	logic [15:0] irq_pending_q;
	logic [15:0] irq_source_q;
	logic [15:0] irq_mask_q;
	logic [31:0] dma_source_q;
	logic [19:0] dma_length_q;
	logic [4:0]  dma_control_q;
	logic [15:0] video_mode_q;
	logic [10:0] snd_irq_en_q;
	logic [7:0]  last_cmd_q;
	logic [31:0] cmd_result_q;
	logic        event_level_q;
	logic [7:0]  event_count_q;

	logic        advance;
	logic [31:0] reg_addr;
	logic [4:0]  sh;
	logic [31:0] lanes;
	logic [31:0] bits;
	logic [31:0] word_val;
	logic [31:0] rd_val;
	logic [31:0] m_ims;
	logic [31:0] m_dma_src;
	logic [31:0] m_dma_len;
	logic [31:0] m_dma_ctl;
	logic [31:0] m_vid;
	logic [31:0] m_snd;

	// stage moves on for writes always, for reads when the response slot frees
	assign advance   = valid_s1 && ((type_s1 == REQ_WRITE) || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;

	// lane placement
	assign reg_addr = {addr_s1[31:2], 2'b00};
	assign sh       = lane_offset(addr_s1[1:0], size_s1);
	assign lanes    = width_mask(size_s1) << sh;
	assign bits     = (wdata_s1 << sh) & lanes;

	// merged register values
	assign m_ims     = merge({16'h0, irq_mask_q}, bits, lanes, WM_IMS);
	assign m_dma_src = merge(dma_source_q, bits, lanes, WM_DMA_SRC);
	assign m_dma_len = merge({12'h0, dma_length_q}, bits, lanes, WM_DMA_LEN);
	assign m_dma_ctl = merge({27'h0, dma_control_q}, bits, lanes, WM_DMA_CTL);
	assign m_vid     = merge({16'h0, video_mode_q}, bits, lanes, WM_VID_MODE);
	assign m_snd     = merge({21'h0, snd_irq_en_q}, bits, lanes, WM_SND_IRQ);

	// read decode
	always_comb begin
		unique case (reg_addr)
			A_DISP_STAT: word_val = DISP_STAT_VAL;
			A_IMS:       word_val = {16'h0, irq_mask_q};
			A_IST:       word_val = {16'h0, (irq_pending_q | irq_source_q) & ~irq_mask_q};
			A_SRC_SET:   word_val = {16'h0, irq_source_q};
			A_DMA_SRC:   word_val = dma_source_q;
			A_DMA_LEN:   word_val = {12'h0, dma_length_q};
			A_DMA_CTL:   word_val = {27'h0, dma_control_q};
			A_CMD_STAT:  word_val = CMD_STAT_VAL;
			A_CMD:       word_val = {24'h0, last_cmd_q};
			A_CMD_RES:   word_val = cmd_result_q;
			A_VID_MODE:  word_val = {16'h0, video_mode_q};
			A_VID_STAT:  word_val = VID_STAT_VAL;
			A_SND_IRQ:   word_val = {21'h0, snd_irq_en_q};
			A_BRIDGE:    word_val = {31'h0, event_level_q};
			A_EV_STAT:   word_val = {23'h0, event_level_q, event_count_q};
			default:     word_val = 32'h0;
		endcase
	end

	assign rd_val = (word_val >> sh) & width_mask(size_s1);

	// request stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			type_s1  <= req_type;
			addr_s1  <= address;
			size_s1  <= access_size;
			wdata_s1 <= write_data;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && (type_s1 == REQ_READ)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (type_s1 == REQ_READ)) begin
			read_data_q <= rd_val;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_pending_q <= '0;
			irq_source_q  <= '0;
			irq_mask_q    <= '0;
			dma_source_q  <= '0;
			dma_length_q  <= '0;
			dma_control_q <= '0;
			video_mode_q  <= '0;
			snd_irq_en_q  <= '0;
			last_cmd_q    <= '0;
			cmd_result_q  <= '0;
			event_level_q <= 1'b0;
			event_count_q <= '0;
		end else if (advance && (type_s1 == REQ_WRITE)) begin
			unique case (reg_addr)
				A_IMS:      irq_mask_q    <= m_ims[15:0];
				A_IST:      irq_pending_q <= irq_pending_q | bits[15:0];
				A_IST_CLR: begin
					irq_pending_q <= irq_pending_q & ~bits[15:0];
					irq_source_q  <= irq_source_q & ~bits[15:0];
				end
				A_SRC_SET:  irq_source_q  <= irq_source_q | bits[15:0];
				A_SRC_CLR:  irq_source_q  <= irq_source_q & ~bits[15:0];
				A_DMA_SRC:  dma_source_q  <= m_dma_src;
				A_DMA_LEN:  dma_length_q  <= m_dma_len[19:0];
				A_DMA_CTL:  dma_control_q <= m_dma_ctl[4:0];
				A_VID_MODE: video_mode_q  <= m_vid[15:0];
				A_SND_IRQ:  snd_irq_en_q  <= m_snd[10:0];
				A_CMD: begin
					last_cmd_q   <= bits[7:0];
					cmd_result_q <= {RESULT_TAG, 16'h0, bits[7:0]};
				end
				A_BRIDGE: begin
					event_level_q                <= bits[0];
					irq_source_q[EVENT_IRQ_BIT]  <= bits[0];
				end
				A_EV_TRIG: begin
					if (bits[0]) begin
						event_count_q               <= event_count_q + 8'd1;
						event_level_q               <= 1'b1;
						irq_source_q[EVENT_IRQ_BIT] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
